>>> rtl/sds_pkg.sv
// Shared types and constants for the seeded digit shuffle.
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;

	localparam int SEED_W    = 32;
	localparam int POS_W     = 4;
	localparam int DIGIT_W   = 4;
	localparam int CHUNK_W   = 8;
	localparam int CHUNK_NUM = SEED_W / CHUNK_W;
	localparam int CNT_W     = $clog2(CHUNK_NUM);

	localparam logic [SEED_W-1:0] LCG_MUL = 32'h0000_3498;
	localparam logic [SEED_W-1:0] LCG_ADD = 32'h0088_1234;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_LCG,
		S_MOD,
		S_READ,
		S_WR_P,
		S_WR_J,
		S_EMIT
	} state_t;

	// Commands from the controller, at most one at a time.
	typedef struct packed {
		logic load;
		logic fill;
		logic lcg;
		logic modr;
		logic read;
		logic wr_p;
		logic wr_j;
		logic emit;
	} dp_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic pos_last;
		logic mod_last;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/sds_ctrl.sv
// Sequencing state machine for the seeded digit shuffle.
`timescale 1ns / 1ps
`default_nettype none
module sds_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sds_pkg::dp_sts_t sts,
	output sds_pkg::dp_cmd_t cmd
);
	import sds_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (sts.pos_last) begin
					state_d = S_LCG;
				end
			end
			S_LCG: begin
				cmd.lcg = 1'b1;
				state_d = S_MOD;
			end
			S_MOD: begin
				cmd.modr = 1'b1;
				if (sts.mod_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_WR_P;
			end
			S_WR_P: begin
				cmd.wr_p = 1'b1;
				state_d  = S_WR_J;
			end
			S_WR_J: begin
				cmd.wr_j = 1'b1;
				state_d  = sts.pos_last ? S_EMIT : S_LCG;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.pos_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/sds_datapath.sv
// Seed generator, remainder unit, digit table and result register.
`timescale 1ns / 1ps
`default_nettype none
module sds_datapath #(
	parameter int NUM_KEYS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sds_pkg::dp_cmd_t             cmd,
	output sds_pkg::dp_sts_t             sts,
	input  logic [sds_pkg::SEED_W-1:0]   seed,
	output logic                         result_strobe,
	output logic [sds_pkg::POS_W-1:0]    position,
	output logic [sds_pkg::DIGIT_W-1:0]  digit,
	output logic                         last
);
	import sds_pkg::*;

	localparam int IDX_W = $clog2(NUM_KEYS);
	localparam int DIV_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NUM_KEYS - 1);

	// Remainder of one chunk of dividend bits, one bit per inner step.
	function automatic logic [IDX_W-1:0] fold_chunk(
		input logic [IDX_W-1:0]   r_in,
		input logic [CHUNK_W-1:0] chunk,
		input logic [DIV_W-1:0]   d
	);
		logic [DIV_W-1:0] t;
		logic [IDX_W-1:0] r;
		r = r_in;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			t = {r, chunk[i]};
			if (t >= d) begin
				t = t - d;
			end
			r = t[IDX_W-1:0];
		end
		return r;
	endfunction

	logic [SEED_W-1:0]  seed_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   rem_q;
	logic [CNT_W-1:0]   div_cnt_q;
	logic [DIGIT_W-1:0] rd_p_q;
	logic [DIGIT_W-1:0] rd_j_q;
	logic               strobe_s1;
	logic [IDX_W-1:0]   pos_s1;
	logic               last_s1;

	logic [DIGIT_W-1:0] tab_mem [NUM_KEYS];

	logic               pos_last;
	logic [IDX_W-1:0]   pos_inc;
	logic [DIV_W-1:0]   divisor;
	logic [CNT_W-1:0]   chunk_sel;
	logic [CHUNK_W-1:0] chunk;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic [DIGIT_W-1:0] mem_wd;

	assign pos_last  = (pos_q == LAST_POS);
	assign pos_inc   = pos_q + 1'b1;
	assign divisor   = {1'b0, pos_q} + 1'b1;
	assign chunk_sel = ~div_cnt_q;
	assign chunk     = seed_q[{chunk_sel, 3'b000} +: CHUNK_W];

	assign sts.pos_last = pos_last;
	assign sts.mod_last = (div_cnt_q == {CNT_W{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			div_cnt_q <= '0;
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= cmd.emit;
			if (cmd.load) begin
				pos_q <= '0;
			end else if (cmd.fill) begin
				pos_q <= pos_last ? IDX_W'(1) : pos_inc;
			end else if (cmd.wr_j || cmd.emit) begin
				pos_q <= pos_last ? '0 : pos_inc;
			end
			if (cmd.lcg) begin
				div_cnt_q <= '0;
			end else if (cmd.modr) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seed_q <= seed;
		end else if (cmd.lcg) begin
			seed_q <= LCG_ADD + seed_q * LCG_MUL;
		end
		if (cmd.lcg) begin
			rem_q <= '0;
		end else if (cmd.modr) begin
			rem_q <= fold_chunk(rem_q, chunk, divisor);
		end
		if (cmd.emit) begin
			pos_s1  <= pos_q;
			last_s1 <= pos_last;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_q;
		mem_wd = DIGIT_W'(pos_q);
		if (cmd.fill) begin
			mem_we = 1'b1;
		end else if (cmd.wr_p) begin
			mem_we = 1'b1;
			mem_wd = rd_j_q;
		end else if (cmd.wr_j) begin
			mem_we = 1'b1;
			mem_wa = rem_q;
			mem_wd = rd_p_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tab_mem[mem_wa] <= mem_wd;
		end
		if (cmd.read || cmd.emit) begin
			rd_p_q <= tab_mem[pos_q];
		end
		if (cmd.read) begin
			rd_j_q <= tab_mem[rem_q];
		end
	end

	assign result_strobe = strobe_s1;
	assign position      = POS_W'(pos_s1);
	assign digit         = rd_p_q;
	assign last          = last_s1;

endmodule
`default_nettype wire

>>> rtl/seeded_digit_shuffle_top.sv
// Top level of the seeded digit shuffle: controller plus datapath.
//
//   channel  | handshake             | fields
//   ---------+-----------------------+------------------------------
//   item in  | start, busy           | seed[31:0]
//   result   | result_strobe         | position[3:0], digit[3:0], last
//
// An item is taken on a clock edge with start high and busy low. It yields
// NUM_KEYS results on consecutive cycles, one strobe each, last on the final.
// Busy stays high from the accepting edge until the final result shows, so a
// new item is taken only once the previous one is through. That
// time comes from the table fill (one write port), and per shuffle step a
// seed update, a four-pass remainder unit (eight bits a pass) and a swap
// through the single-write-port digit table.
// Reset (arst_n low) clears the sequencer and the result strobe at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module seeded_digit_shuffle_top #(
	parameter int NUM_KEYS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [sds_pkg::SEED_W-1:0]   seed,
	output logic                         result_strobe,
	output logic [sds_pkg::POS_W-1:0]    position,
	output logic [sds_pkg::DIGIT_W-1:0]  digit,
	output logic                         last
);
	import sds_pkg::*;

	// Command and status between the sequencer and the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer: fill, nine (NUM_KEYS-1) shuffle steps, then emit.
	sds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath: hold the seed, advance it, reduce it, swap table entries.
	sds_datapath #(
		.NUM_KEYS (NUM_KEYS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.seed          (seed),
		.result_strobe (result_strobe),
		.position      (position),
		.digit         (digit),
		.last          (last)
	);

endmodule
`default_nettype wire

>>> rtl/sds_checker.sv
// Port-level checks for the seeded digit shuffle, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sds_checker #(
	parameter int NUM_KEYS = 10
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_strobe,
	input logic [3:0] position,
	input logic [3:0] digit,
	input logic       last
);
	localparam logic [3:0] LAST_POS = 4'(NUM_KEYS - 1);

	// Results stay within the key range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (position <= LAST_POS) && (digit <= LAST_POS))
		else $error("result outside key range");

	// Last flag marks exactly the final slot.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (last == (position == LAST_POS)))
		else $error("last flag on wrong slot");

	// Slots come out back to back in order.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=> result_strobe && (position == $past(position) + 4'd1))
		else $error("result slots not consecutive");

	// Block is free again when the final slot shows.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |-> !busy)
		else $error("busy after final slot");

	// An accepted item makes the block busy.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted without busy");

endmodule

bind seeded_digit_shuffle_top sds_checker #(.NUM_KEYS(NUM_KEYS)) u_sds_checker (.*);
`default_nettype wire
